/* rtl/rde_pkg.sv */
// ------------------------------------------------------------------------------------------
// rde_pkg
// Shared constants, codes and types of the record deque engine.
// ------------------------------------------------------------------------------------------
package rde_pkg;

   localparam int CAPACITY  = 16;
   localparam int NAME_BITS = 64;
   localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);

   localparam int NAME_W  = 64;
   localparam int COUNT_W = 5;
   localparam int REQ_W   = 72;
   localparam int RSP_W   = 72;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_DELETE     = 3'd4,
      CMD_CLEAR      = 3'd5,
      CMD_LIST       = 3'd6,
      CMD_SIZE       = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_EMPTY     = 2'd1,
      STS_NOT_FOUND = 2'd2,
      STS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic                 wr_en;
      logic [IDX_BITS-1:0]  wr_addr;
      logic [NAME_BITS-1:0] wr_data;
      logic                 rd_en;
      logic [IDX_BITS-1:0]  rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic               valid;
      status_type         status;
      logic [COUNT_W-1:0] count;
      logic [NAME_W-1:0]  name;
      logic               last;
   } res_type;

   function automatic logic [IDX_BITS-1:0] ring_pos(input logic [IDX_BITS-1:0] front,
                                                    input logic [IDX_BITS-1:0] offset);
      logic [IDX_BITS:0] sum;
      sum = {1'b0, front} + {1'b0, offset};
      if (sum >= (IDX_BITS+1)'(CAPACITY)) begin
         sum = sum - (IDX_BITS+1)'(CAPACITY);
      end
      return sum[IDX_BITS-1:0];
   endfunction

endpackage

/* rtl/rde_store.sv */
// ------------------------------------------------------------------------------------------
// rde_store
// Ring storage of the deque: one write port and one registered read port.
// ------------------------------------------------------------------------------------------
module rde_store (
   input  logic                          clock,
   input  rde_pkg::mem_req_type          mem_req,
   output logic [rde_pkg::NAME_BITS-1:0] rd_data
);
   import rde_pkg::*;

   logic [NAME_BITS-1:0] mem_ff [CAPACITY];
   logic [NAME_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rde_ctrl.sv */
// ------------------------------------------------------------------------------------------
// rde_ctrl
// Command sequencer: ring pointers, delete scan and compaction, and list walk.
// ------------------------------------------------------------------------------------------
module rde_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  rde_pkg::cmd_type              cmd,
   input  logic [rde_pkg::NAME_W-1:0]    name_in,
   output rde_pkg::mem_req_type          mem_req,
   input  logic [rde_pkg::NAME_BITS-1:0] rd_data,
   output rde_pkg::res_type              res,
   input  logic                          res_free
);
   import rde_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_EXEC      = 7'b0000010,
      S_DEL_SCAN  = 7'b0000100,
      S_DEL_SHIFT = 7'b0001000,
      S_LIST_RD   = 7'b0010000,
      S_LIST_OUT  = 7'b0100000,
      S_RESP      = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [NAME_BITS-1:0] key_ff, key_in;
   logic [IDX_BITS-1:0]  front_ff, front_in;
   logic [CNT_BITS-1:0]  held_ff, held_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [CNT_BITS-1:0]  cmp_idx_ff, cmp_idx_in;
   logic                 rd_pend_ff, rd_pend_in;
   status_type           status_ff, status_in;
   logic                 full;
   logic                 empty;
   logic                 match;

   assign full      = (held_ff >= CNT_BITS'(CAPACITY));
   assign empty     = (held_ff == '0);
   assign match     = rd_pend_ff && (rd_data == key_ff);
   assign cmd_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      front_in   = front_ff;
      held_in    = held_ff;
      idx_in     = idx_ff;
      cmp_idx_in = cmp_idx_ff;
      rd_pend_in = rd_pend_ff;
      status_in  = status_ff;
      mem_req    = '0;
      res        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd;
               key_in   = name_in[NAME_BITS-1:0];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (res_free) begin
               res.valid  = 1'b1;
               res.status = STS_OK;
               res.last   = 1'b1;
               state_in   = S_IDLE;
               case (cmd_ff)
                  CMD_PUSH_FRONT: begin
                     if (full) begin
                        res.status = STS_FULL;
                     end else begin
                        front_in = (front_ff == '0) ? IDX_BITS'(CAPACITY - 1)
                                                    : front_ff - 1'b1;
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = front_in;
                        mem_req.wr_data = key_ff;
                        held_in         = held_ff + 1'b1;
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (full) begin
                        res.status = STS_FULL;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ring_pos(front_ff, IDX_BITS'(held_ff));
                        mem_req.wr_data = key_ff;
                        held_in         = held_ff + 1'b1;
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (empty) begin
                        res.status = STS_EMPTY;
                     end else begin
                        front_in = ring_pos(front_ff, IDX_BITS'(1));
                        held_in  = held_ff - 1'b1;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (empty) begin
                        res.status = STS_EMPTY;
                     end else begin
                        held_in = held_ff - 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     res.valid  = 1'b0;
                     idx_in     = '0;
                     rd_pend_in = 1'b0;
                     state_in   = S_DEL_SCAN;
                  end
                  CMD_CLEAR: begin
                     held_in  = '0;
                     front_in = '0;
                  end
                  CMD_LIST: begin
                     if (empty) begin
                        res.status = STS_EMPTY;
                     end else begin
                        res.valid = 1'b0;
                        idx_in    = '0;
                        state_in  = S_LIST_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DEL_SCAN: begin
            if (match) begin
               idx_in     = cmp_idx_ff + 1'b1;
               rd_pend_in = 1'b0;
               state_in   = S_DEL_SHIFT;
            end else if (idx_ff < held_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ring_pos(front_ff, IDX_BITS'(idx_ff));
               cmp_idx_in      = idx_ff;
               idx_in          = idx_ff + 1'b1;
               rd_pend_in      = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
               status_in  = STS_NOT_FOUND;
               state_in   = S_RESP;
            end
         end
         S_DEL_SHIFT: begin
            if (rd_pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = ring_pos(front_ff, IDX_BITS'(cmp_idx_ff - 1'b1));
               mem_req.wr_data = rd_data;
            end
            if (idx_ff < held_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ring_pos(front_ff, IDX_BITS'(idx_ff));
               cmp_idx_in      = idx_ff;
               idx_in          = idx_ff + 1'b1;
               rd_pend_in      = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
               held_in    = held_ff - 1'b1;
               status_in  = STS_OK;
               state_in   = S_RESP;
            end
         end
         S_LIST_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ring_pos(front_ff, IDX_BITS'(idx_ff));
            state_in        = S_LIST_OUT;
         end
         S_LIST_OUT: begin
            if (res_free) begin
               res.valid  = 1'b1;
               res.status = STS_OK;
               res.name   = NAME_W'(rd_data);
               res.last   = ((idx_ff + 1'b1) == held_ff);
               idx_in     = idx_ff + 1'b1;
               state_in   = res.last ? S_IDLE : S_LIST_RD;
            end
         end
         S_RESP: begin
            if (res_free) begin
               res.valid  = 1'b1;
               res.status = status_ff;
               res.last   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      res.count = COUNT_W'(held_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         front_ff   <= '0;
         held_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         front_ff   <= front_in;
         held_ff    <= held_in;
         rd_pend_ff <= rd_pend_in;
      end
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      status_ff  <= status_in;
   end

endmodule

/* rtl/record_deque_engine.sv */
// ------------------------------------------------------------------------------------------
// record_deque_engine
// Bounded double-ended queue of name keys held in a ring memory.
//
//   Channel | Direction | Word contents (lowest bit first)
//   req_    | in        | cmd[2:0], name_in[66:3], zero pad
//   rsp_    | out       | status[1:0], entry_count[6:2], name_out[70:7], zero pad; tlast
//
// Push, pop, clear, size and an empty list are taken in S_IDLE and answered from S_EXEC.
// Delete scans the held entries from the front for the key and, when an entry is
// removed, shifts each later entry down one slot; the result follows from S_RESP.
// A list takes one memory read and one result word per entry held.
// No clearing pass follows reset; the output register holds a result while the
// next command is taken, and a stalled result port only holds up the sequencer.
// ------------------------------------------------------------------------------------------
module record_deque_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [rde_pkg::REQ_W-1:0]  req_tdata,   // cmd, name_in
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [rde_pkg::RSP_W-1:0]  rsp_tdata,   // status, entry_count, name_out
   output logic                       rsp_tlast
);
   import rde_pkg::*;

   mem_req_type          mem_req;
   logic [NAME_BITS-1:0] rd_data;
   res_type              res;
   logic                 res_free;

   logic                 out_valid_ff, out_valid_in;
   status_type           out_status_ff;
   logic [COUNT_W-1:0]   out_count_ff;
   logic [NAME_W-1:0]    out_name_ff;
   logic                 out_last_ff;

   rde_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   rde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd_ready (req_tready),
      .cmd       (cmd_type'(req_tdata[2:0])),
      .name_in   (req_tdata[NAME_W+2:3]),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .res       (res),
      .res_free  (res_free)
   );

   assign res_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (res.valid) begin
         out_status_ff <= res.status;
         out_count_ff  <= res.count;
         out_name_ff   <= res.name;
         out_last_ff   <= res.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_W - NAME_W - COUNT_W - 2){1'b0}},
                        out_name_ff, out_count_ff, out_status_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ------------------------------------------------------------------------------------------
// tb
// Self-checking bench for the record deque engine. A directed table covers the empty,
// full and not-found cases, key extremes and every command. Random command streams over a
// small key pool then follow. Each result word is checked against a shadow deque.
// ------------------------------------------------------------------------------------------
module tb;
   import rde_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 60;
   localparam int RANDOM_CMDS = 213;

   typedef struct {
      status_type         status;
      logic [COUNT_W-1:0] count;
      logic [NAME_W-1:0]  name;
      logic               is_last;
   } deque_word_type;

   typedef struct {
      cmd_type           cmd;
      logic [NAME_W-1:0] name;
      int                reps;
      bit                typed;
      status_type        status;
      int                count;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               rsp_tlast;

   logic [NAME_BITS-1:0] shadow_keys [CAPACITY];
   int                   shadow_front = 0;
   int                   shadow_held = 0;
   deque_word_type       awaited_words [$];
   stim_row_type         directed_rows [$];
   logic [NAME_W-1:0]    key_pool [6];
   int                   check_errors = 0;
   int                   burst_left = 0;
   int                   stall_cycles = 0;
   int                   ready_cycle = 0;

   record_deque_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int slot(int offset);
      return (shadow_front + offset) % CAPACITY;
   endfunction

   function automatic void queue_word(status_type st, logic [NAME_W-1:0] name, logic is_last);
      deque_word_type w;
      w.status  = st;
      w.count   = COUNT_W'(shadow_held);
      w.name    = name;
      w.is_last = is_last;
      awaited_words.push_back(w);
   endfunction

   // Applies one command to the shadow deque and queues the words it must produce.
   function automatic void deque_apply(cmd_type cmd, logic [NAME_W-1:0] name_in);
      logic [NAME_BITS-1:0] key;
      status_type           st;
      bit                   found;
      key = name_in[NAME_BITS-1:0];
      st = STS_OK;
      found = 1'b0;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (shadow_held >= CAPACITY) begin
               st = STS_FULL;
            end else begin
               shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
               shadow_keys[shadow_front] = key;
               shadow_held++;
            end
         end
         CMD_PUSH_BACK: begin
            if (shadow_held >= CAPACITY) begin
               st = STS_FULL;
            end else begin
               shadow_keys[slot(shadow_held)] = key;
               shadow_held++;
            end
         end
         CMD_POP_FRONT: begin
            if (shadow_held == 0) begin
               st = STS_EMPTY;
            end else begin
               shadow_front = slot(1);
               shadow_held--;
            end
         end
         CMD_POP_BACK: begin
            if (shadow_held == 0) st = STS_EMPTY;
            else shadow_held--;
         end
         CMD_DELETE: begin
            st = STS_NOT_FOUND;
            for (int k = 0; k < shadow_held; k++) begin
               if (!found && shadow_keys[slot(k)] == key) begin
                  found = 1'b1;
                  for (int j = k; j + 1 < shadow_held; j++) begin
                     shadow_keys[slot(j)] = shadow_keys[slot(j + 1)];
                  end
               end
            end
            if (found) begin
               shadow_held--;
               st = STS_OK;
            end
         end
         CMD_CLEAR: begin
            shadow_held = 0;
            shadow_front = 0;
         end
         CMD_LIST: begin
            if (shadow_held == 0) begin
               queue_word(STS_EMPTY, '0, 1'b1);
            end else begin
               for (int k = 0; k < shadow_held; k++) begin
                  queue_word(STS_OK, NAME_W'(shadow_keys[slot(k)]), k + 1 == shadow_held);
               end
            end
            return;
         end
         default: begin
         end
      endcase
      queue_word(st, '0, 1'b1);
   endfunction

   // Presents one command word, with the sender's bursts and gaps, and waits for it to go.
   task automatic issue(cmd_type cmd, logic [NAME_W-1:0] name);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - NAME_W - 3){1'b0}}, name, cmd};
      deque_apply(cmd, name);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_pause();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_words.size() != 0);
      burst_left = $urandom_range(1, 12);
   endtask

   always @(posedge clock) begin
      ready_cycle <= ready_cycle + 1;
      case ((ready_cycle / 97) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (ready_cycle % 5) != 0;
         default: rsp_tready <= (ready_cycle % 16) >= 12;
      endcase
   end

   always @(posedge clock) begin
      deque_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_words.size() == 0) begin
            $error("result word with nothing expected: tdata %h", rsp_tdata);
            check_errors++;
         end else begin
            w = awaited_words.pop_front();
            if (rsp_tdata[1:0] !== w.status) begin
               $error("status: expected %0d, actual %0d", w.status, rsp_tdata[1:0]);
               check_errors++;
            end
            if (rsp_tdata[6:2] !== w.count) begin
               $error("entry_count: expected %0d, actual %0d", w.count, rsp_tdata[6:2]);
               check_errors++;
            end
            if (rsp_tdata[70:7] !== w.name) begin
               $error("name_out: expected %h, actual %h", w.name, rsp_tdata[70:7]);
               check_errors++;
            end
            if (rsp_tlast !== w.is_last) begin
               $error("last: expected %0d, actual %0d", w.is_last, rsp_tlast);
               check_errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type row;
      cmd_type   cmd;
      int        r;
      bit        filling;
      logic [NAME_W-1:0] key;

      directed_rows.push_back(stim_row_type'{CMD_POP_FRONT, '0, 1, 1, STS_EMPTY, 0});
      directed_rows.push_back(stim_row_type'{CMD_POP_BACK, '1, 1, 1, STS_EMPTY, 0});
      directed_rows.push_back(stim_row_type'{CMD_DELETE, '0, 1, 1, STS_NOT_FOUND, 0});
      directed_rows.push_back(stim_row_type'{CMD_LIST, '0, 1, 1, STS_EMPTY, 0});
      directed_rows.push_back(stim_row_type'{CMD_SIZE, '1, 1, 1, STS_OK, 0});
      directed_rows.push_back(stim_row_type'{CMD_PUSH_BACK, '1, 1, 1, STS_OK, 1});
      directed_rows.push_back(stim_row_type'{CMD_PUSH_FRONT, '0, 1, 1, STS_OK, 2});
      directed_rows.push_back(stim_row_type'{CMD_PUSH_FRONT, 64'h8000_0000_0000_0001, 1, 1,
                                             STS_OK, 3});
      directed_rows.push_back(stim_row_type'{CMD_LIST, '0, 1, 0, STS_OK, 0});
      directed_rows.push_back(stim_row_type'{CMD_DELETE, '1, 1, 1, STS_OK, 2});
      directed_rows.push_back(stim_row_type'{CMD_DELETE, 64'h8000_0000_0000_0000, 1, 1,
                                             STS_NOT_FOUND, 2});
      directed_rows.push_back(stim_row_type'{CMD_PUSH_BACK, 64'h0123_4567_89AB_CDE0, 14, 0,
                                             STS_OK, 0});
      directed_rows.push_back(stim_row_type'{CMD_PUSH_FRONT, '1, 1, 1, STS_FULL, 16});
      directed_rows.push_back(stim_row_type'{CMD_PUSH_BACK, '0, 1, 1, STS_FULL, 16});
      directed_rows.push_back(stim_row_type'{CMD_LIST, '0, 1, 0, STS_OK, 0});
      directed_rows.push_back(stim_row_type'{CMD_DELETE, 64'h0123_4567_89AB_CDE7, 1, 0,
                                             STS_OK, 0});
      directed_rows.push_back(stim_row_type'{CMD_DELETE, 64'h8000_0000_0000_0001, 1, 0,
                                             STS_OK, 0});
      directed_rows.push_back(stim_row_type'{CMD_DELETE, 64'h0123_4567_89AB_CDED, 1, 0,
                                             STS_OK, 0});
      directed_rows.push_back(stim_row_type'{CMD_SIZE, '0, 1, 1, STS_OK, 13});
      directed_rows.push_back(stim_row_type'{CMD_POP_BACK, '0, 1, 1, STS_OK, 12});
      directed_rows.push_back(stim_row_type'{CMD_POP_FRONT, '0, 1, 1, STS_OK, 11});
      directed_rows.push_back(stim_row_type'{CMD_LIST, '0, 1, 0, STS_OK, 0});
      directed_rows.push_back(stim_row_type'{CMD_CLEAR, '1, 1, 1, STS_OK, 0});
      directed_rows.push_back(stim_row_type'{CMD_SIZE, '0, 1, 1, STS_OK, 0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         for (int n = 0; n < row.reps; n++) begin
            issue(row.cmd, row.name + NAME_W'(n));
            if (row.typed) begin
               awaited_words[awaited_words.size() - 1] =
                  deque_word_type'{row.status, COUNT_W'(row.count), '0, 1'b1};
            end
         end
      end

      // Random part: keys mostly come from a small pool so that deletes find matches.
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      filling = 1'b1;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if ($urandom_range(0, 29) == 0) filling = !filling;
         if (n == RANDOM_CMDS / 2) drain_pause();
         r = $urandom_range(0, 99);
         if (r < (filling ? 45 : 20)) cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
         else if (r < 60) cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
         else if (r < 80) cmd = CMD_DELETE;
         else if (r < 90) cmd = CMD_LIST;
         else if (r < 97) cmd = CMD_SIZE;
         else cmd = CMD_CLEAR;
         if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, 5)];
         else key = {$urandom, $urandom};
         issue(cmd, key);
      end

      req_tvalid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (check_errors == 0 && awaited_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
